/* src/wavetable_tone_synth_macros.svh */
// assertion macros for the wavetable tone synth checker
`ifndef WAVETABLE_TONE_SYNTH_MACROS_SVH
`define WAVETABLE_TONE_SYNTH_MACROS_SVH
// property a |-> b, reported by $error
`define WTS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("lbl failed");
// property a |=> b, reported by $error
`define WTS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lbl failed");
`endif

/* src/wts_pkg.sv */
// package: sizes, opcodes and sequencer states of the tone synth
`default_nettype none
package wts_pkg;
  localparam int NumTones     = 4;
  localparam int WaveEntries  = 4096;
  localparam int NumWaveforms = 4;
  localparam int EnvSteps     = 256;
  localparam int NumEnvelopes = 6;

  localparam int ToneW   = 2;
  localparam int WaveAw  = 14;
  localparam int EnvAw   = 11;
  localparam int WaveDepth = NumWaveforms * WaveEntries;
  localparam int EnvDepth  = NumEnvelopes * EnvSteps;

  localparam logic [2:0] MuteCode = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_KEYON = 2'd1,
    OP_WWAVE = 2'd2,
    OP_WENV  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYRD,
    ST_KEYWB,
    ST_TADDR,
    ST_TREAD,
    ST_TMUL,
    ST_TACC,
    ST_OUT
  } state_t;

  // muted when code is the mute code or names no table
  function automatic logic is_muted(input logic [2:0] w);
    return (w == MuteCode) || (w >= 3'(NumWaveforms));
  endfunction
endpackage
`default_nettype wire

/* src/wts_if.sv */
// handshake channel interfaces for input and result words
`default_nettype none
interface wts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  tone_index;
  logic [2:0]  waveform;
  logic [2:0]  envelope;
  logic [31:0] phase_step;
  logic signed [31:0] step_change;
  logic [15:0] volume_step;
  logic [11:0] table_index;
  logic signed [11:0] table_value;
  modport source (output valid, op, tone_index, waveform, envelope, phase_step,
                  step_change, volume_step, table_index, table_value, input ready);
  modport sink (input valid, op, tone_index, waveform, envelope, phase_step,
                step_change, volume_step, table_index, table_value, output ready);
endinterface

interface wts_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [3:0]  active_tones;
  modport source (output valid, left_sample, right_sample, active_tones, input ready);
  modport sink (input valid, left_sample, right_sample, active_tones, output ready);
endinterface
`default_nettype wire

/* src/wts_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module wts_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/wavetable_tone_synth.sv */
// Four-tone wavetable synth. Wave and envelope writes end in the idle state; a key-on
// passes a read and a write-back state (the first envelope value is read from the
// envelope ram). A tick takes each active tone through address, read, multiply and
// accumulate, a muted one through address only; the result waits in the output
// state on out_ch.ready. A small sequencer walks the tones one at a time through
// one shared 12x8 multiplier, one wave and one envelope ram read per tone step.
// The result sits in an output register; a new item is accepted once the tick is
// delivered. Ram contents are undefined until written; nothing clears them.
`default_nettype none
module wavetable_tone_synth (
  input wire logic clk,
  input wire logic rst_n,
  wts_in_if.sink   in_ch,
  wts_out_if.source out_ch
);
  localparam int TW = wts_pkg::ToneW;

  // per-tone state
  logic [31:0] phase_r [wts_pkg::NumTones];
  logic [31:0] inc_r   [wts_pkg::NumTones];
  logic [31:0] sweep_r [wts_pkg::NumTones];
  logic [2:0]  wsel_r  [wts_pkg::NumTones];
  logic [2:0]  esel_r  [wts_pkg::NumTones];
  logic [15:0] pos_r   [wts_pkg::NumTones];
  logic [15:0] pstep_r [wts_pkg::NumTones];
  logic [7:0]  amp_r   [wts_pkg::NumTones];
  logic [7:0]  tick_r;

  wts_pkg::state_t state_r, state_nxt;
  logic [TW-1:0]  tone_r;
  logic [15:0]    left_r, right_r;
  logic [3:0]     act_r;
  logic           out_valid_r;
  logic signed [19:0] prod_r;
  logic           envtick_r;
  logic           envmute_r;

  // held key-on fields
  logic [2:0]  k_wave_r, k_env_r;
  logic [31:0] k_step_r, k_chg_r;
  logic [15:0] k_vstep_r;
  logic        k_env_ok_r;

  logic accept;
  wts_pkg::op_t op;
  assign accept = in_ch.valid && in_ch.ready;
  assign op = wts_pkg::op_t'(in_ch.op);
  assign in_ch.ready = (state_r == wts_pkg::ST_IDLE);

  // ram ports
  logic                     wave_we, env_we;
  logic [wts_pkg::WaveAw-1:0] wave_waddr, wave_raddr;
  logic [wts_pkg::EnvAw-1:0]  env_waddr, env_raddr;
  logic [11:0] wave_rdata;
  logic [7:0]  env_rdata;

  assign wave_we = accept && op == wts_pkg::OP_WWAVE && !wts_pkg::is_muted(in_ch.waveform);
  assign wave_waddr = {in_ch.waveform[1:0], in_ch.table_index};
  assign env_we = accept && op == wts_pkg::OP_WENV &&
                  in_ch.envelope < 3'(wts_pkg::NumEnvelopes) && in_ch.table_index[11:8] == 4'd0;
  assign env_waddr = wts_pkg::EnvAw'({in_ch.envelope, in_ch.table_index[7:0]});

  // current tone's next envelope position
  logic [16:0] pos_sum;
  logic        env_adv;
  assign pos_sum = {1'b0, pos_r[tone_r]} + {1'b0, pstep_r[tone_r]};
  assign env_adv = {1'b0, pos_r[tone_r]} < (17'd65535 - {1'b0, pstep_r[tone_r]});

  // read addresses: key-on reads entry 0, tick reads wave and next envelope
  always_comb begin
    wave_raddr = {wsel_r[tone_r][1:0], phase_r[tone_r][31:20]};
    if (state_r == wts_pkg::ST_IDLE) begin
      env_raddr = wts_pkg::EnvAw'({in_ch.envelope, 8'd0});
    end else if (state_r == wts_pkg::ST_KEYRD) begin
      env_raddr = wts_pkg::EnvAw'({k_env_r, 8'd0});
    end else begin
      env_raddr = wts_pkg::EnvAw'({esel_r[tone_r], pos_sum[15:8]});
    end
  end

  wts_ram #(.Width(12), .Depth(wts_pkg::WaveDepth)) u_wave (
    .clk(clk), .we(wave_we), .waddr(wave_waddr), .wdata(in_ch.table_value),
    .raddr(wave_raddr), .rdata(wave_rdata));
  wts_ram #(.Width(8), .Depth(wts_pkg::EnvDepth)) u_env (
    .clk(clk), .we(env_we), .waddr(env_waddr), .wdata(in_ch.table_value[7:0]),
    .raddr(env_raddr), .rdata(env_rdata));

  logic last_tone;
  assign last_tone = (tone_r == TW'(wts_pkg::NumTones - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wts_pkg::ST_IDLE: begin
        if (accept && op == wts_pkg::OP_KEYON) begin
          state_nxt = wts_pkg::ST_KEYRD;
        end else if (accept && op == wts_pkg::OP_TICK) begin
          state_nxt = wts_pkg::ST_TADDR;
        end
      end
      wts_pkg::ST_KEYRD: state_nxt = wts_pkg::ST_KEYWB;
      wts_pkg::ST_KEYWB: state_nxt = wts_pkg::ST_IDLE;
      wts_pkg::ST_TADDR: begin
        if (wts_pkg::is_muted(wsel_r[tone_r])) begin
          state_nxt = last_tone ? wts_pkg::ST_OUT : wts_pkg::ST_TADDR;
        end else begin
          state_nxt = wts_pkg::ST_TREAD;
        end
      end
      wts_pkg::ST_TREAD: state_nxt = wts_pkg::ST_TMUL;
      wts_pkg::ST_TMUL:  state_nxt = wts_pkg::ST_TACC;
      wts_pkg::ST_TACC:  state_nxt = last_tone ? wts_pkg::ST_OUT : wts_pkg::ST_TADDR;
      wts_pkg::ST_OUT:   state_nxt = (out_valid_r && out_ch.ready) ?
                                     wts_pkg::ST_IDLE : wts_pkg::ST_OUT;
      default:           state_nxt = wts_pkg::ST_IDLE;
    endcase
  end

  // product truncated toward zero for both channels
  logic signed [19:0] l_q, r_q;
  assign l_q = (prod_r < 0) ? -((-prod_r) >>> 6) : (prod_r >>> 6);
  assign r_q = (prod_r < 0) ? -((-prod_r) >>> 4) : (prod_r >>> 4);

  logic [3:0] act_calc;
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      act_calc[t] = (t < wts_pkg::NumTones) ? !wts_pkg::is_muted(wsel_r[t]) : 1'b0;
    end
  end

  // sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wts_pkg::ST_IDLE;
      tone_r      <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < wts_pkg::NumTones; t++) begin
        phase_r[t] <= '0; inc_r[t] <= '0; sweep_r[t] <= '0;
        wsel_r[t] <= wts_pkg::MuteCode; esel_r[t] <= '0;
        pos_r[t] <= '0; pstep_r[t] <= '0; amp_r[t] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        wts_pkg::ST_IDLE: begin
          if (accept && op == wts_pkg::OP_KEYON) begin
            tone_r     <= in_ch.tone_index;
            k_wave_r   <= in_ch.waveform;
            k_env_r    <= in_ch.envelope;
            k_step_r   <= in_ch.phase_step;
            k_chg_r    <= in_ch.step_change;
            k_vstep_r  <= in_ch.volume_step;
            k_env_ok_r <= in_ch.envelope < 3'(wts_pkg::NumEnvelopes);
          end else begin
            tone_r <= '0;
          end
          if (accept && op == wts_pkg::OP_TICK) begin
            tick_r   <= tick_r + 8'd1;
            envtick_r <= (tick_r == 8'hff);
            left_r   <= '0;
            right_r  <= '0;
          end
        end
        wts_pkg::ST_KEYRD: ;
        wts_pkg::ST_KEYWB: begin
          wsel_r[tone_r]  <= k_wave_r;
          esel_r[tone_r]  <= k_env_r;
          phase_r[tone_r] <= '0;
          inc_r[tone_r]   <= k_step_r;
          sweep_r[tone_r] <= k_chg_r;
          pos_r[tone_r]   <= '0;
          pstep_r[tone_r] <= k_vstep_r;
          amp_r[tone_r]   <= k_env_ok_r ? env_rdata : 8'd0;
        end
        wts_pkg::ST_TADDR: begin
          envmute_r <= !env_adv;
          if (wts_pkg::is_muted(wsel_r[tone_r])) begin
            tone_r <= tone_r + TW'(1);
          end
        end
        wts_pkg::ST_TREAD: begin
          phase_r[tone_r] <= phase_r[tone_r] + inc_r[tone_r];
        end
        wts_pkg::ST_TMUL: begin
          prod_r <= $signed(wave_rdata) * $signed({1'b0, amp_r[tone_r]});
          inc_r[tone_r] <= inc_r[tone_r] + sweep_r[tone_r];
        end
        wts_pkg::ST_TACC: begin
          left_r  <= left_r + l_q[15:0];
          right_r <= right_r + r_q[15:0];
          if (envtick_r) begin
            if (!envmute_r) begin
              pos_r[tone_r] <= pos_sum[15:0];
              amp_r[tone_r] <= (esel_r[tone_r] < 3'(wts_pkg::NumEnvelopes)) ?
                               env_rdata : 8'd0;
            end else begin
              wsel_r[tone_r] <= wts_pkg::MuteCode;
              amp_r[tone_r]  <= '0;
              pos_r[tone_r]  <= 16'hffff;
            end
          end
          tone_r <= tone_r + TW'(1);
        end
        wts_pkg::ST_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            act_r       <= act_calc;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r && state_r == wts_pkg::ST_OUT;
  assign out_ch.left_sample  = left_r;
  assign out_ch.right_sample = right_r;
  assign out_ch.active_tones = act_r;
endmodule
`default_nettype wire

/* src/wts_checker.sv */
// port-level checker for the tone synth, bound to the top level
`default_nettype none
`include "wavetable_tone_synth_macros.svh"
module wts_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [1:0] in_op,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] out_left
);
  // no new word is taken while a result waits
  `WTS_ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, !in_ready)
  // a tick is never answered in the very next cycle
  `WTS_ASSERT_NXT(a_tick_lat, clk, rst_n, in_valid && in_ready && in_op == wts_pkg::OP_TICK, !out_valid)
  // a stalled result holds its sample
  `WTS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_left))
  // table writes finish at once
  `WTS_ASSERT_NXT(a_wr_fast, clk, rst_n, in_valid && in_ready && (in_op == wts_pkg::OP_WWAVE || in_op == wts_pkg::OP_WENV), in_ready)
endmodule

bind wavetable_tone_synth wts_checker u_wts_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_op(in_ch.op), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_left(out_ch.left_sample));
`default_nettype wire
